// File: hw/rtl/srps_pkg.sv
package srps_pkg;

	// field widths
	localparam int unsigned CoordW = 21;
	localparam int unsigned DiffW = 22;
	localparam int unsigned DirW = 17;
	localparam int unsigned LenW = 23;
	localparam int unsigned RangeW = 16;
	localparam int unsigned StepW = 13;
	localparam int unsigned MaxPointsDef = 64;

	// register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_MAX_RANGE = 2'd0,
		REG_STEP_MM   = 2'd1,
		REG_ENABLED   = 2'd2,
		REG_NONE      = 2'd3
	} srps_reg_t;

	// walk sequencer
	typedef enum logic [3:0] {
		S_IDLE,
		S_CALC,
		S_MULX,
		S_MULY,
		S_PT,
		S_SQX,
		S_SQY,
		S_TEST,
		S_FLUSH
	} srps_state_t;

	// candidate phase
	typedef enum logic [1:0] {
		PH_START,
		PH_WALK,
		PH_END
	} srps_phase_t;

	// root and divide sequencer
	typedef enum logic [2:0] {
		U_IDLE,
		U_SQA,
		U_SQB,
		U_ROOT,
		U_DIVX,
		U_DIVY,
		U_DONE
	} srps_ustate_t;

	// direction and length handed to the walk sequencer
	typedef struct packed {
		logic                     done;
		logic signed [DirW-1:0]   dir_x;
		logic signed [DirW-1:0]   dir_y;
		logic        [LenW-1:0]   seg_len;
	} srps_dir_t;

endpackage

// File: hw/rtl/srps_if.sv
interface srps_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [srps_pkg::CoordW-1:0] start_x;
	logic signed [srps_pkg::CoordW-1:0] start_y;
	logic signed [srps_pkg::CoordW-1:0] end_x;
	logic signed [srps_pkg::CoordW-1:0] end_y;
	logic signed [srps_pkg::CoordW-1:0] robot_x;
	logic signed [srps_pkg::CoordW-1:0] robot_y;

	modport source (output valid, start_x, start_y, end_x, end_y, robot_x, robot_y,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, robot_x, robot_y,
		output ready);
endinterface

interface srps_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [srps_pkg::CoordW-1:0] point_x;
	logic signed [srps_pkg::CoordW-1:0] point_y;
	logic                                last_of_run;
	logic                                truncated;

	modport source (output valid, point_x, point_y, last_of_run, truncated, input ready);
	modport sink (input valid, point_x, point_y, last_of_run, truncated, output ready);
endinterface

// File: hw/rtl/srps_root_div.sv
module srps_root_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [srps_pkg::DiffW-1:0]  dx,
	input  logic signed [srps_pkg::DiffW-1:0]  dy,
	output srps_pkg::srps_dir_t                 res
);
	import srps_pkg::*;

	localparam int unsigned SqW = 2 * DiffW;
	localparam int unsigned RadW = 60;
	localparam int unsigned RootW = RadW / 2;
	localparam int unsigned RemW = 32;
	localparam int unsigned NumW = 47;
	localparam int unsigned QW = DirW;
	localparam int unsigned SubW = 35;

	srps_ustate_t st_q, st_d;

	logic signed [DiffW-1:0] dx_q, dy_q;
	logic        [SqW-1:0]   acc_q;
	logic        [RadW-1:0]  rad_q;
	logic        [RemW-1:0]  rem_q;
	logic        [RootW-1:0] root_q;
	logic        [4:0]       cnt_q;
	logic        [QW-1:0]    num_q;
	logic        [QW-1:0]    quo_q;
	logic        [RootW:0]   den_q;
	logic signed [DirW-1:0]  dir_x_q, dir_y_q;
	logic        [LenW-1:0]  seg_q;

	logic signed [DiffW-1:0] sq_op;
	logic signed [SqW-1:0]   sq;
	logic        [SqW-1:0]   s_sum;
	logic        [SubW-1:0]  sub_a, sub_b, diff;
	logic                    ge;
	logic        [RootW-1:0] root_nxt;
	logic        [RemW-1:0]  rem_nxt;
	logic        [RootW-1:0] r8;
	logic        [DiffW-1:0] mag;
	logic        [NumW-1:0]  num;
	logic        [QW-1:0]    quo_nxt;
	logic signed [DirW-1:0]  dir_nxt;
	logic                    last_it;

	// one squarer for dx then dy
	assign sq_op = (st_q == U_SQA) ? dx_q : dy_q;
	assign sq = sq_op * sq_op;
	assign s_sum = acc_q + SqW'(sq);

	// shared compare and subtract
	always_comb begin
		if (st_q == U_ROOT) begin
			sub_a = SubW'({rem_q, rad_q[RadW-1 -: 2]});
			sub_b = SubW'({root_q, 2'b01});
		end else begin
			sub_a = SubW'({rem_q[RootW:0], num_q[QW-1]});
			sub_b = SubW'(den_q);
		end
	end
	assign diff = sub_a - sub_b;
	assign ge = !diff[SubW-1];

	assign root_nxt = {root_q[RootW-2:0], ge};
	assign rem_nxt = ge ? diff[RemW-1:0] : sub_a[RemW-1:0];
	assign quo_nxt = {quo_q[QW-2:0], ge};
	assign last_it = (cnt_q == '0);

	// divider setup for the next axis
	assign r8 = (st_q == U_ROOT) ? root_nxt : root_q;
	assign mag = (st_q == U_ROOT) ? (dx_q[DiffW-1] ? DiffW'(-dx_q) : DiffW'(dx_q))
		: (dy_q[DiffW-1] ? DiffW'(-dy_q) : DiffW'(dy_q));
	assign num = {1'b0, mag, 24'b0} + NumW'(r8);

	assign dir_nxt = ((st_q == U_DIVX) ? dx_q[DiffW-1] : dy_q[DiffW-1])
		? DirW'(-$signed({1'b0, quo_nxt[QW-2:0]}))
		: $signed(quo_nxt);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			U_IDLE: if (start) st_d = U_SQA;
			U_SQA:  st_d = U_SQB;
			U_SQB:  st_d = U_ROOT;
			U_ROOT: if (last_it) st_d = (root_nxt == '0) ? U_DONE : U_DIVX;
			U_DIVX: if (last_it) st_d = U_DIVY;
			U_DIVY: if (last_it) st_d = U_DONE;
			U_DONE: st_d = U_IDLE;
			default: st_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= U_IDLE;
		else st_q <= st_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			U_IDLE: begin
				if (start) begin
					dx_q <= dx;
					dy_q <= dy;
					acc_q <= '0;
				end
			end
			U_SQA: acc_q <= s_sum;
			U_SQB: begin
				rad_q <= {s_sum, 16'b0};
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= 5'(RootW - 1);
			end
			U_ROOT: begin
				rad_q <= {rad_q[RadW-3:0], 2'b00};
				rem_q <= rem_nxt;
				root_q <= root_nxt;
				cnt_q <= cnt_q - 5'd1;
				if (last_it) begin
					seg_q <= LenW'(root_nxt[RootW-1:8])
						+ LenW'((rem_nxt != '0) || (root_nxt[7:0] != '0));
					dir_x_q <= '0;
					dir_y_q <= '0;
					den_q <= {root_nxt, 1'b0};
					rem_q <= RemW'(num[NumW-1:QW]);
					num_q <= num[QW-1:0];
					cnt_q <= 5'(QW - 1);
				end
			end
			U_DIVX, U_DIVY: begin
				rem_q <= ge ? diff[RemW-1:0] : sub_a[RemW-1:0];
				num_q <= {num_q[QW-2:0], 1'b0};
				quo_q <= quo_nxt;
				cnt_q <= cnt_q - 5'd1;
				if (last_it) begin
					if (st_q == U_DIVX) begin
						dir_x_q <= dir_nxt;
						rem_q <= RemW'(num[NumW-1:QW]);
						num_q <= num[QW-1:0];
						cnt_q <= 5'(QW - 1);
					end else begin
						dir_y_q <= dir_nxt;
					end
				end
			end
			default: ;
		endcase
	end

	assign res.done = (st_q == U_DONE);
	assign res.dir_x = dir_x_q;
	assign res.dir_y = dir_y_q;
	assign res.seg_len = seg_q;

endmodule

// File: hw/rtl/segment_range_point_sampler_unit.sv
// channel   dir  fields                                          beat when
// seg_in    in   start_x/y end_x/y robot_x/y (21b signed)       valid && ready
// pt_out    out  point_x/y (21b signed) last_of_run truncated   valid && ready
// apb       in   max_range @0x0, step_mm @0x4, enabled @0x8     psel&&penable&&pwrite
//
// the root and divide unit runs two squares, 30 root steps, 17 divide steps per axis
// and a hand-off, skipping the divides when the segment has zero length
// start and end points use S_SQX, S_SQY, S_TEST, walk samples S_MULX, S_MULY, S_PT first,
// all through one multiplier; the walk runs to the segment length unless the point
// limit ends it, then S_FLUSH; a result waits in a pending register and a stall on pt_out
// holds the sequencer; reset: max_range 0, step_mm 100, enabled 1, sequencer idle
module segment_range_point_sampler_unit #(
	parameter int unsigned MAX_POINTS = srps_pkg::MaxPointsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	srps_in_if.sink     seg_in,
	srps_out_if.source  pt_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srps_pkg::*;

	localparam int unsigned CntW = $clog2(MAX_POINTS + 1);
	localparam int unsigned MulW = 24;
	localparam int unsigned ProdW = 2 * MulW;
	localparam int unsigned OffW = 26;
	localparam int unsigned D2W = 45;

	// config registers
	logic [RangeW-1:0] max_range_q;
	logic [StepW-1:0]  step_mm_q;
	logic              enabled_q;
	srps_reg_t         reg_idx;

	srps_state_t st_q, st_d;
	srps_phase_t ph_q;

	logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q, rx_q, ry_q;
	logic        [31:0]       lim_q;
	logic        [StepW-1:0]  step_q;
	logic        [LenW-1:0]   gone_q;
	logic signed [DirW-1:0]   dirx_q, diry_q;
	logic        [LenW-1:0]   seg_q;
	logic signed [ProdW-1:0]  prod_q;
	logic        [D2W-1:0]    acc_q;
	logic signed [OffW-1:0]   ox_q;
	logic signed [CoordW-1:0] px_q, py_q;
	logic        [CntW-1:0]   cnt_q;
	logic                     trunc_q;
	logic                     pend_valid_q;
	logic signed [CoordW-1:0] pend_x_q, pend_y_q;
	logic                     out_valid_q, out_last_q, out_trunc_q;
	logic signed [CoordW-1:0] out_x_q, out_y_q;

	srps_dir_t               ures;
	logic                    accept, go;
	logic signed [MulW-1:0]  mul_a, mul_b;
	logic signed [ProdW-1:0] mul_p;
	logic signed [DiffW-1:0] dex, dey;
	logic        [D2W-1:0]   d2;
	logic                    qual, full, out_free, take, adv, push_last;
	logic        [LenW:0]    gone_nxt;
	logic                    walk_more;

	function automatic logic signed [OffW-1:0] rnd15(input logic signed [ProdW-1:0] p);
		logic [ProdW-1:0] m;
		logic [ProdW-1:0] q;
		m = p[ProdW-1] ? ProdW'(-p) : ProdW'(p);
		q = (m + ProdW'(1 << 14)) >> 15;
		return p[ProdW-1] ? OffW'(-$signed(q[OffW-1:0])) : $signed(q[OffW-1:0]);
	endfunction

	function automatic logic signed [CoordW-1:0] sat21(input logic signed [OffW-1:0] v);
		if (v > OffW'(1048575)) return CoordW'(1048575);
		if (v < -OffW'(1048576)) return CoordW'(-1048576);
		return v[CoordW-1:0];
	endfunction

	// apb config port
	assign pready = 1'b1;
	assign reg_idx = srps_reg_t'(paddr[3:2]);
	always_comb begin
		unique case (reg_idx)
			REG_MAX_RANGE: prdata = 32'(max_range_q);
			REG_STEP_MM:   prdata = 32'(step_mm_q);
			REG_ENABLED:   prdata = 32'(enabled_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= '0;
			step_mm_q <= StepW'(100);
			enabled_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MAX_RANGE: max_range_q <= pwdata[RangeW-1:0];
				REG_STEP_MM:   step_mm_q <= pwdata[StepW-1:0];
				REG_ENABLED:   enabled_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// root and divide unit
	srps_root_div u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go),
		.dx     (DiffW'(seg_in.end_x) - DiffW'(seg_in.start_x)),
		.dy     (DiffW'(seg_in.end_y) - DiffW'(seg_in.start_y)),
		.res    (ures)
	);

	// control and datapath decode
	assign seg_in.ready = (st_q == S_IDLE);
	assign accept = seg_in.valid && seg_in.ready;
	assign go = accept && enabled_q;

	assign dex = DiffW'(px_q) - DiffW'(rx_q);
	assign dey = DiffW'(py_q) - DiffW'(ry_q);
	assign d2 = acc_q + D2W'(prod_q);
	assign gone_nxt = {1'b0, gone_q} + (LenW+1)'(step_q);

	always_comb begin
		unique case (st_q)
			S_MULX: begin
				mul_a = $signed({1'b0, gone_q});
				mul_b = MulW'(dirx_q);
			end
			S_MULY: begin
				mul_a = $signed({1'b0, gone_q});
				mul_b = MulW'(diry_q);
			end
			S_SQX: begin
				mul_a = MulW'(dex);
				mul_b = MulW'(dex);
			end
			default: begin
				mul_a = MulW'(dey);
				mul_b = MulW'(dey);
			end
		endcase
		mul_p = mul_a * mul_b;
		qual = (d2 < D2W'(lim_q));
		full = (cnt_q >= CntW'(MAX_POINTS));
		out_free = !out_valid_q || pt_out.ready;
		take = (st_q == S_TEST) && qual && !full && (!pend_valid_q || out_free);
		adv = (st_q == S_TEST) && (!qual || take);
		push_last = (st_q == S_FLUSH) && pend_valid_q && out_free;
		walk_more = (ph_q == PH_START) ? (seg_q != '0) : (gone_nxt < (LenW+1)'(seg_q));
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE:  if (go) st_d = S_CALC;
			S_CALC:  if (ures.done) st_d = S_SQX;
			S_MULX:  st_d = S_MULY;
			S_MULY:  st_d = S_PT;
			S_PT:    st_d = S_SQX;
			S_SQX:   st_d = S_SQY;
			S_SQY:   st_d = S_TEST;
			S_TEST: begin
				if (qual && full) st_d = S_FLUSH;
				else if (adv) begin
					if (ph_q == PH_END) st_d = S_FLUSH;
					else st_d = walk_more ? S_MULX : S_SQX;
				end
			end
			S_FLUSH: if (!pend_valid_q || out_free) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (go) begin
			sx_q <= seg_in.start_x;
			sy_q <= seg_in.start_y;
			ex_q <= seg_in.end_x;
			ey_q <= seg_in.end_y;
			rx_q <= seg_in.robot_x;
			ry_q <= seg_in.robot_y;
			lim_q <= 32'(max_range_q) * 32'(max_range_q);
			step_q <= (step_mm_q == '0) ? StepW'(1) : step_mm_q;
		end
		if (st_q == S_CALC && ures.done) begin
			dirx_q <= ures.dir_x;
			diry_q <= ures.dir_y;
			seg_q <= ures.seg_len;
			px_q <= sx_q;
			py_q <= sy_q;
			ph_q <= PH_START;
		end
		if (st_q == S_MULX || st_q == S_MULY || st_q == S_SQX || st_q == S_SQY)
			prod_q <= mul_p;
		if (st_q == S_MULY) ox_q <= rnd15(prod_q);
		if (st_q == S_PT) begin
			px_q <= sat21(OffW'(sx_q) + ox_q);
			py_q <= sat21(OffW'(sy_q) + rnd15(prod_q));
		end
		if (st_q == S_SQY) acc_q <= D2W'(prod_q);
		if (take) begin
			pend_x_q <= px_q;
			pend_y_q <= py_q;
		end
		if (adv && ph_q != PH_END) begin
			if (ph_q == PH_START) gone_q <= '0;
			else gone_q <= gone_nxt[LenW-1:0];
			if (!walk_more) begin
				px_q <= ex_q;
				py_q <= ey_q;
				ph_q <= PH_END;
			end else begin
				ph_q <= PH_WALK;
			end
		end
		if ((take && pend_valid_q) || push_last) begin
			out_x_q <= pend_x_q;
			out_y_q <= pend_y_q;
			out_last_q <= push_last;
			out_trunc_q <= push_last && trunc_q;
		end
	end

	// run control and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			trunc_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				cnt_q <= '0;
				trunc_q <= 1'b0;
			end
			if (st_q == S_TEST && qual && full) trunc_q <= 1'b1;
			if (take) begin
				cnt_q <= cnt_q + CntW'(1);
				pend_valid_q <= 1'b1;
			end
			if (push_last) pend_valid_q <= 1'b0;
			if ((take && pend_valid_q) || push_last) out_valid_q <= 1'b1;
			else if (pt_out.ready) out_valid_q <= 1'b0;
		end
	end

	assign pt_out.valid = out_valid_q;
	assign pt_out.point_x = out_x_q;
	assign pt_out.point_y = out_y_q;
	assign pt_out.last_of_run = out_last_q;
	assign pt_out.truncated = out_trunc_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MAX_POINTS))
		else $error("result count beyond limit");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_trunc_q |-> out_last_q)
		else $error("truncated flag without last beat");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		push_last |=> !pend_valid_q && st_q == S_IDLE)
		else $error("pending result left after last beat");

	a_busy_after_go: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> st_q == S_CALC)
		else $error("sequencer did not start");

	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		ures.done |-> st_q == S_CALC)
		else $error("root unit finished while walk sequencer not waiting");

endmodule
